// ===== design/assert_macros.svh =====
// assertion macros shared by the list engine modules
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== design/bole_pkg.sv =====
// shared types, codes and the microcode program of the list engine
// no dependencies
package bole_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned FILL_W = 7;
  localparam int unsigned STEP_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_EDIT   = 3'd3,
    OP_GET    = 3'd4,
    OP_FIND   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef logic [STEP_W-1:0] step_t;

  // program addresses
  localparam step_t S_IDLE   = 5'd0;
  localparam step_t S_A0     = 5'd1;
  localparam step_t S_A1     = 5'd2;
  localparam step_t S_I0     = 5'd3;
  localparam step_t S_I1     = 5'd4;
  localparam step_t S_I2     = 5'd5;
  localparam step_t S_I3     = 5'd6;
  localparam step_t S_I4     = 5'd7;
  localparam step_t S_D0     = 5'd8;
  localparam step_t S_D1     = 5'd9;
  localparam step_t S_D2     = 5'd10;
  localparam step_t S_D3     = 5'd11;
  localparam step_t S_D4     = 5'd12;
  localparam step_t S_E0     = 5'd13;
  localparam step_t S_E1     = 5'd14;
  localparam step_t S_G0     = 5'd15;
  localparam step_t S_G1     = 5'd16;
  localparam step_t S_G2     = 5'd17;
  localparam step_t S_F0     = 5'd18;
  localparam step_t S_F1     = 5'd19;
  localparam step_t S_F2     = 5'd20;
  localparam step_t S_F3     = 5'd21;
  localparam step_t S_FULLX  = 5'd22;
  localparam step_t S_EMPTYX = 5'd23;
  localparam step_t S_BADX   = 5'd24;
  localparam step_t S_NFX    = 5'd25;
  localparam step_t S_EMIT   = 5'd26;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_FULL,
    C_EMPTY,
    C_POS_GT_CNT,
    C_POS_GE_CNT,
    C_IDX_NE_POS,
    C_IDX_MORE,
    C_IDX_GE_CNT,
    C_SCAN_GO,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [2:0] {
    IX_HOLD,
    IX_CNT,
    IX_POS,
    IX_ZERO,
    IX_INC,
    IX_DEC
  } idx_op_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_POS,
    RD_POS_P1,
    RD_CNT_M1,
    RD_IDX_M2,
    RD_IDX_P1,
    RD_IDX_P2,
    RD_ZERO
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CNT_VAL,
    WR_POS_VAL,
    WR_IDX_RD
  } wr_sel_e;

  typedef enum logic [1:0] {
    CN_HOLD,
    CN_INC,
    CN_DEC
  } cnt_op_e;

  typedef enum logic [1:0] {
    RV_ZERO,
    RV_RD,
    RV_IDX
  } res_sel_e;

  // one microcode word
  typedef struct packed {
    cond_e    cond;
    step_t    target;
    logic     act_if_jump;  // datapath actions only when the jump is taken
    idx_op_e  idx_op;
    rd_sel_e  rd_sel;
    wr_sel_e  wr_sel;
    cnt_op_e  cnt_op;
    logic     set_st;
    status_e  st;
    res_sel_e res_sel;
    logic     done;
  } ctrl_t;

  // datapath conditions seen by the sequencer
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic idx_ne_pos;
    logic idx_more;
    logic idx_ge_cnt;
    logic scan_go;
  } flags_t;

  localparam ctrl_t CTRL_NOP = '{
    cond: C_NEVER, target: S_IDLE, act_if_jump: 1'b0, idx_op: IX_HOLD,
    rd_sel: RD_NONE, wr_sel: WR_NONE, cnt_op: CN_HOLD, set_st: 1'b0,
    st: ST_OK, res_sel: RV_ZERO, done: 1'b0
  };

  // entry point of each request
  function automatic step_t dispatch(input logic [OP_W-1:0] op);
    step_t s;
    case (op)
      OP_APPEND: s = S_A0;
      OP_INSERT: s = S_I0;
      OP_DELETE: s = S_D0;
      OP_EDIT:   s = S_E0;
      OP_GET:    s = S_G0;
      OP_FIND:   s = S_F0;
      default:   s = S_BADX;
    endcase
    return s;
  endfunction

  // control store
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t cw;
    cw = CTRL_NOP;
    case (step)
      S_A0: begin
        cw.cond   = C_FULL;
        cw.target = S_FULLX;
      end
      S_A1: begin
        cw.wr_sel = WR_CNT_VAL;
        cw.cnt_op = CN_INC;
        cw.set_st = 1'b1;
        cw.cond   = C_ALWAYS;
        cw.target = S_EMIT;
      end
      S_I0: begin
        cw.cond   = C_FULL;
        cw.target = S_FULLX;
      end
      S_I1: begin
        cw.cond   = C_POS_GT_CNT;
        cw.target = S_BADX;
      end
      S_I2: begin
        cw.idx_op = IX_CNT;
        cw.rd_sel = RD_CNT_M1;
      end
      S_I3: begin
        cw.cond        = C_IDX_NE_POS;
        cw.target      = S_I3;
        cw.act_if_jump = 1'b1;
        cw.wr_sel      = WR_IDX_RD;
        cw.idx_op      = IX_DEC;
        cw.rd_sel      = RD_IDX_M2;
      end
      S_I4: begin
        cw.wr_sel = WR_POS_VAL;
        cw.cnt_op = CN_INC;
        cw.set_st = 1'b1;
        cw.cond   = C_ALWAYS;
        cw.target = S_EMIT;
      end
      S_D0: begin
        cw.cond   = C_EMPTY;
        cw.target = S_EMPTYX;
      end
      S_D1: begin
        cw.cond   = C_POS_GE_CNT;
        cw.target = S_BADX;
      end
      S_D2: begin
        cw.idx_op = IX_POS;
        cw.rd_sel = RD_POS_P1;
      end
      S_D3: begin
        cw.cond        = C_IDX_MORE;
        cw.target      = S_D3;
        cw.act_if_jump = 1'b1;
        cw.wr_sel      = WR_IDX_RD;
        cw.idx_op      = IX_INC;
        cw.rd_sel      = RD_IDX_P2;
      end
      S_D4: begin
        cw.cnt_op = CN_DEC;
        cw.set_st = 1'b1;
        cw.cond   = C_ALWAYS;
        cw.target = S_EMIT;
      end
      S_E0: begin
        cw.cond   = C_POS_GE_CNT;
        cw.target = S_BADX;
      end
      S_E1: begin
        cw.wr_sel = WR_POS_VAL;
        cw.set_st = 1'b1;
        cw.cond   = C_ALWAYS;
        cw.target = S_EMIT;
      end
      S_G0: begin
        cw.cond   = C_EMPTY;
        cw.target = S_EMPTYX;
      end
      S_G1: begin
        cw.cond   = C_POS_GE_CNT;
        cw.target = S_BADX;
        cw.rd_sel = RD_POS;
      end
      S_G2: begin
        cw.set_st  = 1'b1;
        cw.res_sel = RV_RD;
        cw.cond    = C_ALWAYS;
        cw.target  = S_EMIT;
      end
      S_F0: begin
        cw.idx_op = IX_ZERO;
        cw.rd_sel = RD_ZERO;
      end
      S_F1: begin
        cw.cond        = C_SCAN_GO;
        cw.target      = S_F1;
        cw.act_if_jump = 1'b1;
        cw.idx_op      = IX_INC;
        cw.rd_sel      = RD_IDX_P1;
      end
      S_F2: begin
        cw.cond   = C_IDX_GE_CNT;
        cw.target = S_NFX;
      end
      S_F3: begin
        cw.set_st  = 1'b1;
        cw.res_sel = RV_IDX;
        cw.cond    = C_ALWAYS;
        cw.target  = S_EMIT;
      end
      S_FULLX: begin
        cw.set_st = 1'b1;
        cw.st     = ST_FULL;
        cw.cond   = C_ALWAYS;
        cw.target = S_EMIT;
      end
      S_EMPTYX: begin
        cw.set_st = 1'b1;
        cw.st     = ST_EMPTY;
        cw.cond   = C_ALWAYS;
        cw.target = S_EMIT;
      end
      S_BADX: begin
        cw.set_st = 1'b1;
        cw.st     = ST_BADIDX;
        cw.cond   = C_ALWAYS;
        cw.target = S_EMIT;
      end
      S_NFX: begin
        cw.set_st = 1'b1;
        cw.st     = ST_NOTFOUND;
        cw.cond   = C_ALWAYS;
        cw.target = S_EMIT;
      end
      S_EMIT: begin
        cw.cond   = C_OUT_BUSY;
        cw.target = S_EMIT;
        cw.done   = 1'b1;
      end
      default: cw = CTRL_NOP;
    endcase
    return cw;
  endfunction

endpackage

// ===== design/bole_seq.sv =====
// microcode sequencer: step counter, control store lookup, conditional jumps
// depends on bole_pkg and assert_macros.svh
`include "assert_macros.svh"

module bole_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bole_pkg::OP_W-1:0]  op_i,
  input  bole_pkg::flags_t           flags_i,
  input  logic                       out_busy_i,
  output bole_pkg::ctrl_t            ctrl_o,
  output logic                       idle_o,
  output logic                       done_o
);
  import bole_pkg::*;

  step_t step_q, step_d;
  ctrl_t cw;
  logic  jump;
  logic  act;

  assign cw = ucode(step_q);

  always_comb begin
    case (cw.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_FULL:       jump = flags_i.full;
      C_EMPTY:      jump = flags_i.empty;
      C_POS_GT_CNT: jump = flags_i.pos_gt_cnt;
      C_POS_GE_CNT: jump = flags_i.pos_ge_cnt;
      C_IDX_NE_POS: jump = flags_i.idx_ne_pos;
      C_IDX_MORE:   jump = flags_i.idx_more;
      C_IDX_GE_CNT: jump = flags_i.idx_ge_cnt;
      C_SCAN_GO:    jump = flags_i.scan_go;
      C_OUT_BUSY:   jump = out_busy_i;
      default:      jump = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (step_q == S_IDLE) begin
      step_d = start_i ? dispatch(op_i) : S_IDLE;
    end else if (cw.done && !jump) begin
      step_d = S_IDLE;
    end else if (jump) begin
      step_d = cw.target;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  // control outputs
  always_comb begin
    act    = !cw.act_if_jump || jump;
    ctrl_o = cw;
    if (!act) begin
      ctrl_o.idx_op = IX_HOLD;
      ctrl_o.rd_sel = RD_NONE;
      ctrl_o.wr_sel = WR_NONE;
      ctrl_o.cnt_op = CN_HOLD;
      ctrl_o.set_st = 1'b0;
    end
    idle_o = (step_q == S_IDLE);
    done_o = cw.done && !jump;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  `ASSERT_RST(done_to_idle, clk_i, rst_ni, done_o |=> idle_o, "no return to idle after done")

endmodule

// ===== design/bole_dp.sv =====
// list datapath: entry memory, fill count, walk index and result registers
// depends on bole_pkg and assert_macros.svh
`include "assert_macros.svh"

module bole_dp #(
  parameter int unsigned CAPACITY   = bole_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [bole_pkg::POS_W-1:0]  position_i,
  input  logic [bole_pkg::VAL_W-1:0]  value_in_i,
  input  bole_pkg::ctrl_t             ctrl_i,
  output bole_pkg::flags_t            flags_o,
  output bole_pkg::status_e           status_o,
  output logic [bole_pkg::VAL_W-1:0]  value_out_o,
  output logic [bole_pkg::FILL_W-1:0] fill_count_o,
  output logic                        is_full_o,
  output logic                        is_empty_o
);
  import bole_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [DATA_WIDTH-1:0] rd_q;
  status_e               st_q;
  logic [VAL_W-1:0]      res_q;

  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];

  logic [XW-1:0]         pos_x, cnt_x, idx_x;
  logic [XW:0]           idx_p1;
  logic [XW-1:0]         rd_addr_x, wr_addr_x;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic                  rd_en, wr_en;
  logic [DATA_WIDTH-1:0] wr_data;

  assign pos_x  = XW'(pos_q);
  assign cnt_x  = XW'(cnt_q);
  assign idx_x  = XW'(idx_q);
  assign idx_p1 = (XW+1)'(idx_x) + (XW+1)'(1);

  always_comb begin
    flags_o.full       = (cnt_q == CW'(CAPACITY));
    flags_o.empty      = (cnt_q == '0);
    flags_o.pos_gt_cnt = (pos_x > cnt_x);
    flags_o.pos_ge_cnt = (pos_x >= cnt_x);
    flags_o.idx_ne_pos = (idx_x != pos_x);
    flags_o.idx_more   = (idx_p1 < (XW+1)'(cnt_x));
    flags_o.idx_ge_cnt = (idx_x >= cnt_x);
    flags_o.scan_go    = (idx_x < cnt_x) && (rd_q != val_q);
  end

  // memory ports
  always_comb begin
    case (ctrl_i.rd_sel)
      RD_POS:    rd_addr_x = pos_x;
      RD_POS_P1: rd_addr_x = pos_x + XW'(1);
      RD_CNT_M1: rd_addr_x = cnt_x - XW'(1);
      RD_IDX_M2: rd_addr_x = idx_x - XW'(2);
      RD_IDX_P1: rd_addr_x = idx_x + XW'(1);
      RD_IDX_P2: rd_addr_x = idx_x + XW'(2);
      default:   rd_addr_x = '0;
    endcase
    rd_en = (ctrl_i.rd_sel != RD_NONE);

    case (ctrl_i.wr_sel)
      WR_CNT_VAL: begin
        wr_addr_x = cnt_x;
        wr_data   = val_q;
      end
      WR_POS_VAL: begin
        wr_addr_x = pos_x;
        wr_data   = val_q;
      end
      WR_IDX_RD: begin
        wr_addr_x = idx_x;
        wr_data   = rd_q;
      end
      default: begin
        wr_addr_x = '0;
        wr_data   = val_q;
      end
    endcase
    wr_en = (ctrl_i.wr_sel != WR_NONE);

    rd_addr = AW'(rd_addr_x);
    wr_addr = AW'(wr_addr_x);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    case (ctrl_i.idx_op)
      IX_CNT:  idx_d = cnt_q;
      IX_POS:  idx_d = CW'(pos_q);
      IX_ZERO: idx_d = '0;
      IX_INC:  idx_d = idx_q + CW'(1);
      IX_DEC:  idx_d = idx_q - CW'(1);
      default: idx_d = idx_q;
    endcase
    case (ctrl_i.cnt_op)
      CN_INC:  cnt_d = cnt_q + CW'(1);
      CN_DEC:  cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (load_i) begin
      pos_q <= position_i;
      val_q <= DATA_WIDTH'(value_in_i);
    end
    if (ctrl_i.set_st) begin
      st_q <= ctrl_i.st;
      case (ctrl_i.res_sel)
        RV_RD:   res_q <= VAL_W'(rd_q);
        RV_IDX:  res_q <= VAL_W'(idx_q);
        default: res_q <= '0;
      endcase
    end
  end

  assign status_o     = st_q;
  assign value_out_o  = res_q;
  assign fill_count_o = FILL_W'(cnt_q);
  assign is_full_o    = flags_o.full;
  assign is_empty_o   = flags_o.empty;

  `ASSERT_RST(cnt_step_one, clk_i, rst_ni, (cnt_q != $past(cnt_q)) |-> ((cnt_q == $past(cnt_q) + CW'(1)) || (cnt_q == $past(cnt_q) - CW'(1))), "fill count moved by more than one")
  `ASSERT_NEVER(cnt_over_cap, clk_i, rst_ni, cnt_q > CW'(CAPACITY), "fill count above capacity")
  `ASSERT_NEVER(wr_out_of_range, clk_i, rst_ni, wr_en && (wr_addr_x >= XW'(CAPACITY)), "entry write beyond capacity")

endmodule

// ===== design/bounded_ordered_list_engine.sv =====
// top level of the bounded ordered list engine
// depends on bole_pkg, bole_seq, bole_dp and assert_macros.svh
`include "assert_macros.svh"

// Ordered list of up to CAPACITY words with append, insert, delete, edit, get
// and find requests; each request beat yields exactly one result beat carrying
// a status code, a value, the fill count and full/empty flags. A small
// microcoded sequencer walks the entry memory (one write and one read port,
// registered read) one entry per cycle, so insert, delete and find take longer
// the more entries they walk: insert shifts the entries from the end of the
// list down to the position, delete shifts those above the position, and
// find scans from entry zero up to the match or the fill count. A request
// can also be turned away by a status check (list full, list empty, bad
// index); an undefined op gets the bad index status. The emit step holds
// while an earlier result beat is still pending downstream.
// A new request is taken only while the sequencer is idle, but a
// finished result waits in the output register without blocking that accept.
// Entries need no clearing after reset: only entries below the fill count
// ever reach a result or a shift.

module bounded_ordered_list_engine #(
  parameter int unsigned CAPACITY   = bole_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bole_pkg::OP_W-1:0]   op_i,
  input  logic [bole_pkg::POS_W-1:0]  position_i,
  input  logic [bole_pkg::VAL_W-1:0]  value_in_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic [bole_pkg::VAL_W-1:0]  value_out_o,
  output logic [bole_pkg::FILL_W-1:0] fill_count_o,
  output logic                        is_full_o,
  output logic                        is_empty_o
);
  import bole_pkg::*;

  // sequencer <-> datapath
  ctrl_t   ctrl;
  flags_t  flags;
  logic    seq_idle;
  logic    seq_done;
  logic    in_accept;
  logic    out_busy;

  // datapath result, valid while the sequencer sits on its emit step
  status_e          dp_status;
  logic [VAL_W-1:0] dp_value;
  logic [FILL_W-1:0] dp_fill;
  logic             dp_full;
  logic             dp_empty;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [2:0]        status_q;
  logic [VAL_W-1:0]  value_q;
  logic [FILL_W-1:0] fill_q;
  logic              full_q;
  logic              empty_q;

  // a request beat is taken whenever the sequencer is idle
  assign in_ready_o = seq_idle;
  assign in_accept  = in_valid_i && in_ready_o;

  // the emit step holds while an older result still waits downstream
  assign out_busy = out_valid_q && !out_ready_i;

  bole_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .op_i       (op_i),
    .flags_i    (flags),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl),
    .idle_o     (seq_idle),
    .done_o     (seq_done)
  );

  bole_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_accept),
    .position_i   (position_i),
    .value_in_i   (value_in_i),
    .ctrl_i       (ctrl),
    .flags_o      (flags),
    .status_o     (dp_status),
    .value_out_o  (dp_value),
    .fill_count_o (dp_fill),
    .is_full_o    (dp_full),
    .is_empty_o   (dp_empty)
  );

  // result beat valid: set on emit, cleared when taken
  always_comb begin
    if (seq_done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, captured on the emit step
  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      status_q <= dp_status;
      value_q  <= dp_value;
      fill_q   <= dp_fill;
      full_q   <= dp_full;
      empty_q  <= dp_empty;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign value_out_o  = value_q;
  assign fill_count_o = fill_q;
  assign is_full_o    = full_q;
  assign is_empty_o   = empty_q;

  // an accepted request always takes the sequencer out of idle
  `ASSERT_RST(accept_leaves_idle, clk_i, rst_ni, in_accept |=> !in_ready_o, "idle after accept")
  // a pending result beat is never overwritten
  `ASSERT_NEVER(no_result_overwrite, clk_i, rst_ni, seq_done && out_busy, "result overwritten")

endmodule
